// ----- sv/nearest_probe_lookup_top_assert.svh -----
// ----------------------------------------------------------------------------
// Nearest probe lookup assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NEAREST_PROBE_LOOKUP_TOP_ASSERT_SVH
`define NEAREST_PROBE_LOOKUP_TOP_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define NPL_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("nearest_probe_lookup: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define NPL_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("nearest_probe_lookup: next-cycle check failed");

`endif

// ----- sv/npl_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest probe lookup package
// Shared types, command codes and the distance helper.
// ----------------------------------------------------------------------------
package npl_pkg;

  localparam int PROBE_DEPTH_DEF = 1024;
  localparam int COORD_W = 24;
  localparam int ATTR_W = 16;
  localparam int DIFF_W = COORD_W + 1;
  localparam int SQ_W = 2 * DIFF_W;
  localparam int DIST_W = SQ_W;
  localparam int OUT_IDX_W = 10;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [ATTR_W-1:0] attr_t;
  typedef logic [DIFF_W-1:0] diff_t;
  typedef logic [SQ_W-1:0] sq_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } probe_pos_t;

  typedef struct packed {
    attr_t sky;
    attr_t amb_b;
    attr_t amb_g;
    attr_t amb_r;
  } probe_attr_t;

  typedef struct packed {
    logic issue;
    logic first;
  } scan_ctl_t;

  function automatic diff_t abs_diff(input coord_t a, input coord_t b);
    logic signed [DIFF_W-1:0] d;
    d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    return d[DIFF_W-1] ? diff_t'(-d) : diff_t'(d);
  endfunction

endpackage

// ----- sv/npl_if.sv -----
// ----------------------------------------------------------------------------
// Nearest probe lookup channels
// Command channel and result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface npl_req_if;
  logic valid;
  logic ready;
  logic [1:0] cmd;
  npl_pkg::coord_t in_x;
  npl_pkg::coord_t in_y;
  npl_pkg::coord_t in_z;
  npl_pkg::attr_t in_amb_r;
  npl_pkg::attr_t in_amb_g;
  npl_pkg::attr_t in_amb_b;
  npl_pkg::attr_t in_sky;

  modport source (
    output valid, cmd, in_x, in_y, in_z, in_amb_r, in_amb_g, in_amb_b, in_sky,
    input ready
  );
  modport sink (
    input valid, cmd, in_x, in_y, in_z, in_amb_r, in_amb_g, in_amb_b, in_sky,
    output ready
  );
endinterface

interface npl_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic [npl_pkg::OUT_IDX_W-1:0] nearest_index;
  npl_pkg::attr_t out_amb_r;
  npl_pkg::attr_t out_amb_g;
  npl_pkg::attr_t out_amb_b;
  npl_pkg::attr_t out_sky;

  modport source (
    output valid, found, nearest_index, out_amb_r, out_amb_g, out_amb_b, out_sky,
    input ready
  );
  modport sink (
    input valid, found, nearest_index, out_amb_r, out_amb_g, out_amb_b, out_sky,
    output ready
  );
endinterface

// ----- sv/npl_store.sv -----
// ----------------------------------------------------------------------------
// Nearest probe lookup probe store
// Position memory and attribute memory, one write port and one registered
// read port each.
// ----------------------------------------------------------------------------
module npl_store #(
  parameter int PROBE_DEPTH = npl_pkg::PROBE_DEPTH_DEF,
  localparam int IDX_W = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [IDX_W-1:0]        waddr,
  input  npl_pkg::probe_pos_t     wpos,
  input  npl_pkg::probe_attr_t    wattr,
  input  logic                    pos_re,
  input  logic [IDX_W-1:0]        pos_raddr,
  output npl_pkg::probe_pos_t     pos_q,
  input  logic                    attr_re,
  input  logic [IDX_W-1:0]        attr_raddr,
  output npl_pkg::probe_attr_t    attr_q
);

  npl_pkg::probe_pos_t  pos_mem  [PROBE_DEPTH];
  npl_pkg::probe_attr_t attr_mem [PROBE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      pos_mem[waddr] <= wpos;
    end
    if (pos_re) begin
      pos_q <= pos_mem[pos_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      attr_mem[waddr] <= wattr;
    end
    if (attr_re) begin
      attr_q <= attr_mem[attr_raddr];
    end
  end

endmodule

// ----- sv/npl_scan.sv -----
// ----------------------------------------------------------------------------
// Nearest probe lookup distance pipeline
// Takes one stored position a cycle, forms the squared distance to the query
// point in three stages and keeps the closest index.
// ----------------------------------------------------------------------------
module npl_scan #(
  parameter int PROBE_DEPTH = npl_pkg::PROBE_DEPTH_DEF,
  localparam int IDX_W = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  npl_pkg::scan_ctl_t    ctl,
  input  logic [IDX_W-1:0]      issue_idx,
  input  npl_pkg::probe_pos_t   query,
  input  npl_pkg::probe_pos_t   pos_q,
  output logic                  busy,
  output logic [IDX_W-1:0]      best_idx
);

  logic [3:0] valid;
  logic [3:0] first;
  logic [IDX_W-1:0] idx [4];

  npl_pkg::diff_t dx, dy, dz;
  npl_pkg::sq_t sx, sy, sz;
  npl_pkg::dist_t dsum;
  npl_pkg::dist_t best_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[2:0], ctl.issue};
    end
  end

  always_ff @(posedge clk) begin
    first <= {first[2:0], ctl.first};
    idx[0] <= issue_idx;
    idx[1] <= idx[0];
    idx[2] <= idx[1];
    idx[3] <= idx[2];
    dx <= npl_pkg::abs_diff(query.x, pos_q.x);
    dy <= npl_pkg::abs_diff(query.y, pos_q.y);
    dz <= npl_pkg::abs_diff(query.z, pos_q.z);
    sx <= dx * dx;
    sy <= dy * dy;
    sz <= dz * dz;
    dsum <= sx + sy + sz;
    if (valid[3] && (first[3] || (dsum < best_d))) begin
      best_d <= dsum;
      best_idx <= idx[3];
    end
  end

  assign busy = |valid;

endmodule

// ----- sv/nearest_probe_lookup_top.sv -----
// ----------------------------------------------------------------------------
// Nearest probe lookup top level
// Command decode, scan sequencing and the result register.
// ----------------------------------------------------------------------------
// Clear and load items are done as they are accepted. A query over N
// stored probes reads the position memory once per probe through its
// single read port, waits while the distance pipeline drains and until it
// is seen empty, fetches the winning probe's attributes and loads the
// result register before the next item is taken; a query on an empty
// table skips the scan and goes straight to the result register. A query
// waits longer while the output register still holds a result that has
// not been taken. One item is worked on at a time, and a finished result
// waits in the output register while the next item is taken. No clearing
// pass is run after reset: only entries below the probe count are ever read.
module nearest_probe_lookup_top #(
  parameter int PROBE_DEPTH = npl_pkg::PROBE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst,
  npl_req_if.sink   req,
  npl_rsp_if.source rsp
);

  `include "nearest_probe_lookup_top_assert.svh"

  localparam int IDX_W = (PROBE_DEPTH > 1) ? $clog2(PROBE_DEPTH) : 1;
  localparam int CNT_W = $clog2(PROBE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FETCH = 2'd2;
  localparam logic [1:0] ST_RESULT = 2'd3;

  logic [1:0] state, state_next;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_q;
  logic [CNT_W-1:0] rd_cnt;
  logic empty_q;
  npl_pkg::probe_pos_t query;

  logic accept;
  logic we;
  logic load_out;
  npl_pkg::scan_ctl_t ctl;
  logic scan_busy;
  logic [IDX_W-1:0] best_idx;
  logic [npl_pkg::OUT_IDX_W-1:0] best_out_idx;
  npl_pkg::probe_pos_t wpos;
  npl_pkg::probe_attr_t wattr;
  npl_pkg::probe_pos_t pos_q;
  npl_pkg::probe_attr_t attr_q;

  logic out_valid;
  logic out_found;
  logic [npl_pkg::OUT_IDX_W-1:0] out_idx;
  npl_pkg::probe_attr_t out_attr;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == ST_IDLE);
  assign we = accept && (req.cmd == npl_pkg::CMD_LOAD) && (count < CNT_W'(PROBE_DEPTH));
  assign wpos = '{z: req.in_z, y: req.in_y, x: req.in_x};
  assign wattr = '{sky: req.in_sky, amb_b: req.in_amb_b, amb_g: req.in_amb_g,
                   amb_r: req.in_amb_r};

  assign ctl.issue = (state == ST_SCAN) && (rd_cnt != n_q);
  assign ctl.first = (rd_cnt == '0);
  assign load_out = (state == ST_RESULT) && (!out_valid || rsp.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.cmd == npl_pkg::CMD_QUERY)) begin
          state_next = (count == '0) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rd_cnt == n_q) && !scan_busy) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      rd_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (req.cmd)
          npl_pkg::CMD_CLEAR: count <= '0;
          npl_pkg::CMD_LOAD: begin
            if (we) begin
              count <= count + CNT_W'(1);
            end
          end
          npl_pkg::CMD_QUERY: rd_cnt <= '0;
          default: ;
        endcase
      end else if (ctl.issue) begin
        rd_cnt <= rd_cnt + CNT_W'(1);
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.cmd == npl_pkg::CMD_QUERY)) begin
      query <= wpos;
      n_q <= count;
      empty_q <= (count == '0);
    end
    if (load_out) begin
      out_found <= !empty_q;
      out_idx <= empty_q ? '0 : best_out_idx;
      out_attr <= empty_q ? '0 : attr_q;
    end
  end

  generate
    if (IDX_W >= npl_pkg::OUT_IDX_W) begin : g_idx_trunc
      assign best_out_idx = best_idx[npl_pkg::OUT_IDX_W-1:0];
    end else begin : g_idx_ext
      assign best_out_idx = {{(npl_pkg::OUT_IDX_W - IDX_W){1'b0}}, best_idx};
    end
  endgenerate

  npl_store #(
    .PROBE_DEPTH(PROBE_DEPTH)
  ) u_store (
    .clk       (clk),
    .we        (we),
    .waddr     (count[IDX_W-1:0]),
    .wpos      (wpos),
    .wattr     (wattr),
    .pos_re    (ctl.issue),
    .pos_raddr (rd_cnt[IDX_W-1:0]),
    .pos_q     (pos_q),
    .attr_re   (state == ST_FETCH),
    .attr_raddr(best_idx),
    .attr_q    (attr_q)
  );

  npl_scan #(
    .PROBE_DEPTH(PROBE_DEPTH)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .issue_idx(rd_cnt[IDX_W-1:0]),
    .query    (query),
    .pos_q    (pos_q),
    .busy     (scan_busy),
    .best_idx (best_idx)
  );

  assign rsp.valid = out_valid;
  assign rsp.found = out_found;
  assign rsp.nearest_index = out_idx;
  assign rsp.out_amb_r = out_attr.amb_r;
  assign rsp.out_amb_g = out_attr.amb_g;
  assign rsp.out_amb_b = out_attr.amb_b;
  assign rsp.out_sky = out_attr.sky;

  `NPL_ASSERT_IMPLY(a_count_bound, 1'b1, count <= CNT_W'(PROBE_DEPTH))
  `NPL_ASSERT_IMPLY(a_scan_bound, state == ST_SCAN, rd_cnt <= n_q)
  `NPL_ASSERT_IMPLY(a_fetch_drained, state == ST_FETCH, !scan_busy)
  `NPL_ASSERT_NEXT(a_query_scans,
    accept && (req.cmd == npl_pkg::CMD_QUERY) && (count != '0), state == ST_SCAN)

endmodule
